@@ rtl/isbq_pkg.sv @@
// Shared constants, types and controller state encoding for the interval store.
`default_nettype none
package isbq_pkg;

    localparam int CAPACITY   = 256;
    localparam int COORD_BITS = 16;
    localparam int QUERY_BITS = COORD_BITS + 1;
    localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [QUERY_BITS-1:0] t_qval;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [CNT_W-1:0]      t_cnt;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic ins_start;  // insert beat accepted: write table, load result
        logic qry_start;  // query beat accepted: capture window, clear best
        logic rd_issue;   // read the entry at the scan pointer and advance
        logic load_best;  // load the scan result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic last_addr;
    } t_dp_sts;

endpackage
`default_nettype wire

@@ rtl/isbq_if.sv @@
// Valid/ready channel interfaces for request and response beats.
`default_nettype none
interface isbq_req_if;
    import isbq_pkg::*;
    logic   valid;
    logic   ready;
    logic   req_type;
    t_coord iv_left;
    t_coord iv_right;
    t_qval  query_left_limit;
    t_qval  query_end_low;
    t_qval  query_end_high;

    modport source (output valid, req_type, iv_left, iv_right, query_left_limit,
                    query_end_low, query_end_high, input ready);
    modport sink   (input valid, req_type, iv_left, iv_right, query_left_limit,
                    query_end_low, query_end_high, output ready);
endinterface

interface isbq_rsp_if;
    import isbq_pkg::*;
    logic   valid;
    logic   ready;
    logic   found;
    t_coord match_left;
    t_coord match_right;
    logic   store_full;

    modport source (output valid, found, match_left, match_right, store_full,
                    input ready);
    modport sink   (input valid, found, match_left, match_right, store_full,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/isbq_ctrl.sv @@
// Controller: request handshake, scan sequencing and output valid.
`default_nettype none
module isbq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_req_type,
    output logic                   o_in_ready,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output isbq_pkg::t_dp_cmd      o_cmd,
    input  wire isbq_pkg::t_dp_sts i_sts
);
    import isbq_pkg::*;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   w_accept;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_vld || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_vld;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && i_req_type == REQ_QUERY && !i_sts.count_zero) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.last_addr) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        n_out_vld = r_out_vld && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.ins_start = (i_req_type == REQ_INSERT);
                    o_cmd.qry_start = (i_req_type == REQ_QUERY);
                    // inserts, and queries on an empty store, answer at once
                    if (i_req_type == REQ_INSERT || i_sts.count_zero) begin
                        n_out_vld = 1'b1;
                    end
                end
            end
            ST_SCAN:  o_cmd.rd_issue = 1'b1;
            ST_DRAIN: ;
            ST_DONE: begin
                o_cmd.load_best = 1'b1;
                n_out_vld       = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule
`default_nettype wire

@@ rtl/isbq_dp.sv @@
// Datapath: interval tables, entry count, scan compare and result register.
`default_nettype none
module isbq_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire isbq_pkg::t_dp_cmd i_cmd,
    output isbq_pkg::t_dp_sts      o_sts,
    input  wire isbq_pkg::t_coord  i_iv_left,
    input  wire isbq_pkg::t_coord  i_iv_right,
    input  wire isbq_pkg::t_qval   i_limit,
    input  wire isbq_pkg::t_qval   i_end_low,
    input  wire isbq_pkg::t_qval   i_end_high,
    output logic                   o_found,
    output isbq_pkg::t_coord       o_match_left,
    output isbq_pkg::t_coord       o_match_right,
    output logic                   o_store_full
);
    import isbq_pkg::*;

    t_coord r_left_mem  [CAPACITY];
    t_coord r_right_mem [CAPACITY];

    t_cnt   r_count;
    t_addr  r_rd_addr;
    logic   r_rd_vld;
    t_coord r_rd_left, r_rd_right;
    t_qval  r_limit, r_end_low, r_end_high;
    logic   r_best_found;
    t_coord r_best_left, r_best_right;
    logic   r_out_found, r_out_full;
    t_coord r_out_left, r_out_right;

    logic   w_full;
    t_qval  w_end;
    logic   w_match;

    assign w_full           = (r_count == t_cnt'(CAPACITY));
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.last_addr  = (t_cnt'(r_rd_addr) == r_count - t_cnt'(1));

    // right + 1 is one bit wider, so it never wraps
    assign w_end   = t_qval'(r_rd_right) + t_qval'(1);
    assign w_match = r_rd_vld && (t_qval'(r_rd_left) < r_limit)
                     && (w_end >= r_end_low) && (w_end < r_end_high);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_start && !w_full) begin
            r_left_mem[r_count[ADDR_W-1:0]]  <= i_iv_left;
            r_right_mem[r_count[ADDR_W-1:0]] <= i_iv_right;
        end
        r_rd_left  <= r_left_mem[r_rd_addr];
        r_rd_right <= r_right_mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.ins_start && !w_full) begin
                r_count <= r_count + t_cnt'(1);
            end
            r_rd_vld <= i_cmd.rd_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.qry_start) begin
            r_limit      <= i_limit;
            r_end_low    <= i_end_low;
            r_end_high   <= i_end_high;
            r_rd_addr    <= '0;
            r_best_found <= 1'b0;
            r_best_left  <= '0;
            r_best_right <= '0;
        end else begin
            if (i_cmd.rd_issue) begin
                r_rd_addr <= r_rd_addr + t_addr'(1);
            end
            // later entries win ties on equal left
            if (w_match && (!r_best_found || r_rd_left >= r_best_left)) begin
                r_best_found <= 1'b1;
                r_best_left  <= r_rd_left;
                r_best_right <= r_rd_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_start || i_cmd.qry_start) begin
            r_out_found <= 1'b0;
            r_out_left  <= '0;
            r_out_right <= '0;
            r_out_full  <= i_cmd.ins_start && w_full;
        end else if (i_cmd.load_best) begin
            r_out_found <= r_best_found;
            r_out_left  <= r_best_left;
            r_out_right <= r_best_right;
            r_out_full  <= 1'b0;
        end
    end

    assign o_found       = r_out_found;
    assign o_match_left  = r_out_left;
    assign o_match_right = r_out_right;
    assign o_store_full  = r_out_full;

endmodule
`default_nettype wire

@@ rtl/interval_store_bounded_query.sv @@
// Interval store with a windowed best-match query: top level.
//
// Requests arrive on i_req, one beat per item; req_type 0 appends
// (iv_left, iv_right) to the table, req_type 1 searches it. Each request
// yields exactly one response beat on o_rsp.
// An insert answers from a result register in the cycle after its beat;
// store_full is set when the table already held CAPACITY entries and the
// interval was dropped.
// A query walks the table one entry per cycle through the single read port
// of the table memory, then passes a drain state and a done state that
// loads the best match into the result register; on an empty store a query
// answers like an insert. A new request is taken once the controller is
// idle and the response register is free.
// A stalled receiver holds the response steady; one request can be taken
// in the same cycle the waiting response is consumed, not before.
// Synchronous reset empties the store (entry count to zero) and drops any
// pending response; table contents are not cleared.
`default_nettype none
module interval_store_bounded_query (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    isbq_req_if.sink   i_req,
    isbq_rsp_if.source o_rsp
);
    import isbq_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    isbq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    isbq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_iv_left     (i_req.iv_left),
        .i_iv_right    (i_req.iv_right),
        .i_limit       (i_req.query_left_limit),
        .i_end_low     (i_req.query_end_low),
        .i_end_high    (i_req.query_end_high),
        .o_found       (o_rsp.found),
        .o_match_left  (o_rsp.match_left),
        .o_match_right (o_rsp.match_right),
        .o_store_full  (o_rsp.store_full)
    );

endmodule
`default_nettype wire

@@ rtl/isbq_checker.sv @@
// Port-level checks for the interval store, bound to the top level.
`default_nettype none
module isbq_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_req_ready,
    input wire logic              i_rsp_valid,
    input wire logic              i_rsp_ready,
    input wire logic              i_found,
    input wire isbq_pkg::t_coord  i_match_left,
    input wire isbq_pkg::t_coord  i_match_right,
    input wire logic              i_store_full
);
    import isbq_pkg::*;

    // reset drops any pending response
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // a stalled response blocks new requests
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |-> !i_req_ready)
        else $error("request taken while response stalled");

    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_found && i_store_full))
        else $error("found and store_full both set");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_found) |-> (i_match_left == '0 && i_match_right == '0))
        else $error("miss carries nonzero interval");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_found) && $stable(i_match_left)
             && $stable(i_match_right) && $stable(i_store_full)))
        else $error("stalled response changed");

endmodule

bind interval_store_bounded_query isbq_checker u_isbq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_found       (o_rsp.found),
    .i_match_left  (o_rsp.match_left),
    .i_match_right (o_rsp.match_right),
    .i_store_full  (o_rsp.store_full)
);
`default_nettype wire

@@ verif/isbq_answer_checker.sv @@
// Checker for the interval store: predicts every answer and compares it with the response beats.
`default_nettype none
module isbq_answer_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    isbq_req_if       i_req,
    isbq_rsp_if       i_rsp,
    output int        o_mismatches,
    output int        o_answers_pending
);
    import isbq_pkg::*;

    typedef struct packed {
        logic   found;
        t_coord match_left;
        t_coord match_right;
        logic   store_full;
    } t_answer;

    t_coord  stored_left  [CAPACITY];
    t_coord  stored_right [CAPACITY];
    int      stored_count = 0;
    int      answers_seen = 0;
    t_answer answers_due [$];

    initial begin
        o_mismatches      = 0;
        o_answers_pending = 0;
    end

    // Append one interval, or flag the drop once the table is full.
    function automatic t_answer store_interval(t_coord left, t_coord right);
        t_answer ans;
        ans = '0;
        if (stored_count >= CAPACITY) begin
            ans.store_full = 1'b1;
        end else begin
            stored_left[stored_count]  = left;
            stored_right[stored_count] = right;
            stored_count++;
        end
        return ans;
    endfunction

    // Greatest left among matches; later entries win ties.
    function automatic t_answer search_store(t_qval limit, t_qval end_lo, t_qval end_hi);
        t_answer best;
        t_qval   end_pt;
        best = '0;
        for (int i = 0; i < stored_count; i++) begin
            end_pt = t_qval'(stored_right[i]) + t_qval'(1);
            if (t_qval'(stored_left[i]) < limit && end_pt >= end_lo && end_pt < end_hi &&
                (!best.found || stored_left[i] >= best.match_left)) begin
                best.found       = 1'b1;
                best.match_left  = stored_left[i];
                best.match_right = stored_right[i];
            end
        end
        return best;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (o_mismatches < 100)
            $display("checker: answer %0d %s got %0h want %0h", answers_seen, what, got, want);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            answers_due.delete();
            stored_count = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got = {i_rsp.found, i_rsp.match_left, i_rsp.match_right, i_rsp.store_full};
                if (answers_due.size() == 0) begin
                    report_mismatch("unexpected beat", 0, 0);
                end else begin
                    want = answers_due.pop_front();
                    if (got.found !== want.found)
                        report_mismatch("found", got.found, want.found);
                    if (got.match_left !== want.match_left)
                        report_mismatch("match_left", got.match_left, want.match_left);
                    if (got.match_right !== want.match_right)
                        report_mismatch("match_right", got.match_right, want.match_right);
                    if (got.store_full !== want.store_full)
                        report_mismatch("store_full", got.store_full, want.store_full);
                end
                answers_seen++;
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.req_type == REQ_INSERT)
                    answers_due.push_back(store_interval(i_req.iv_left, i_req.iv_right));
                else
                    answers_due.push_back(search_store(i_req.query_left_limit,
                                                       i_req.query_end_low,
                                                       i_req.query_end_high));
            end
        end
        o_answers_pending = answers_due.size();
    end

endmodule
`default_nettype wire

@@ verif/tb_interval_store_bounded_query.sv @@
// Testbench top for the interval store: clock, reset, request and response traffic, verdict.
`default_nettype none
module tb_interval_store_bounded_query;
    import isbq_pkg::*;

    localparam int RANDOM_ITEMS = 1880;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int WINDOW_TOP   = 65536;

    typedef struct {
        logic   kind;
        t_coord left;
        t_coord right;
        t_qval  limit;
        t_qval  end_lo;
        t_qval  end_hi;
    } t_request;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int     mismatches;
    int     answers_pending;
    int     send_burst   = 0;
    int     inserts_sent = 0;
    t_coord known_left [$];
    t_coord known_right [$];

    always #4 i_clk = ~i_clk;

    isbq_req_if req_ch ();
    isbq_rsp_if rsp_ch ();

    interval_store_bounded_query dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    isbq_answer_checker u_answer_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req             (req_ch),
        .i_rsp             (rsp_ch),
        .o_mismatches      (mismatches),
        .o_answers_pending (answers_pending)
    );

    function automatic t_coord pick_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return t_coord'($urandom_range(0, 63));
            default: return t_coord'($urandom());
        endcase
    endfunction

    function automatic t_request insert_req(t_coord left, t_coord right);
        t_request rq;
        rq.kind   = REQ_INSERT;
        rq.left   = left;
        rq.right  = right;
        rq.limit  = t_qval'($urandom());
        rq.end_lo = t_qval'($urandom());
        rq.end_hi = t_qval'($urandom());
        return rq;
    endfunction

    function automatic t_request query_req(int limit, int end_lo, int end_hi);
        t_request rq;
        rq.kind   = REQ_QUERY;
        rq.left   = t_coord'($urandom());
        rq.right  = t_coord'($urandom());
        rq.limit  = t_qval'(limit);
        rq.end_lo = t_qval'(end_lo);
        rq.end_hi = t_qval'(end_hi);
        return rq;
    endfunction

    // Aim most windows at a stored interval so that matches and near misses are common.
    function automatic t_request random_query();
        int sel;
        int k;
        int lim;
        int end_pt;
        int lo;
        int hi;
        sel = $urandom_range(0, 9);
        if (known_left.size() > 0 && sel < 6) begin
            k      = $urandom_range(0, known_left.size() - 1);
            lim    = int'(known_left[k]) + $urandom_range(0, 2);
            end_pt = int'(known_right[k]) + 1;
            lo     = end_pt - $urandom_range(0, 3);
            hi     = end_pt + $urandom_range(0, 40);
            if ($urandom_range(0, 3) == 0)
                lim = WINDOW_TOP;
            if (lo < 0)
                lo = 0;
            if (hi > WINDOW_TOP)
                hi = WINDOW_TOP;
            return query_req(lim, lo, hi);
        end else if (sel == 6) begin
            return query_req(WINDOW_TOP, 0, WINDOW_TOP);
        end else if (sel == 7) begin
            lo = $urandom_range(0, WINDOW_TOP);
            return query_req($urandom_range(0, WINDOW_TOP), lo, $urandom_range(0, lo));
        end else begin
            lo = $urandom_range(0, WINDOW_TOP);
            hi = $urandom_range(0, WINDOW_TOP);
            if (lo > hi)
                return query_req($urandom_range(0, WINDOW_TOP), hi, lo);
            return query_req($urandom_range(0, WINDOW_TOP), lo, hi);
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_request(t_request rq);
        int gap;
        if (send_burst > 0) begin
            gap = 0;
            send_burst--;
        end else begin
            gap = $urandom_range(0, 19);
            if ($urandom_range(0, 24) == 0)
                send_burst = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.req_type         = rq.kind;
        req_ch.iv_left          = rq.left;
        req_ch.iv_right         = rq.right;
        req_ch.query_left_limit = rq.limit;
        req_ch.query_end_low    = rq.end_lo;
        req_ch.query_end_high   = rq.end_hi;
        req_ch.valid            = 1'b1;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        @(negedge i_clk);
        if (rq.kind == REQ_INSERT) begin
            inserts_sent++;
            if (known_left.size() < CAPACITY) begin
                known_left.push_back(rq.left);
                known_right.push_back(rq.right);
            end
        end
    endtask

    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (answers_pending != 0)
            @(negedge i_clk);
    endtask

    initial begin
        req_ch.valid            = 1'b0;
        req_ch.req_type         = REQ_INSERT;
        req_ch.iv_left          = '0;
        req_ch.iv_right         = '0;
        req_ch.query_left_limit = '0;
        req_ch.query_end_low    = '0;
        req_ch.query_end_high   = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(query_req(WINDOW_TOP, 0, WINDOW_TOP));
        send_request(insert_req(16'h0000, 16'h0000));
        send_request(insert_req(16'hffff, 16'hffff));
        send_request(insert_req(16'd100, 16'd200));
        send_request(insert_req(16'd100, 16'd300));
        send_request(insert_req(16'd100, 16'd200));
        send_request(insert_req(16'hffff, 16'hfffe));
        // right at maximum: its end of 65536 falls outside every window
        send_request(query_req(WINDOW_TOP, 0, WINDOW_TOP));
        send_request(query_req(WINDOW_TOP, WINDOW_TOP, WINDOW_TOP));
        send_request(query_req(WINDOW_TOP, 300, 200));
        send_request(query_req(0, 0, WINDOW_TOP));
        send_request(query_req(1, 0, WINDOW_TOP));
        send_request(query_req(65535, 0, WINDOW_TOP));
        send_request(query_req(65535, 201, 301));
        send_request(query_req(65535, 202, 302));
        send_request(query_req(WINDOW_TOP, 65535, WINDOW_TOP));
        send_request(insert_req(16'h5555, 16'haaaa));
        send_request(insert_req(16'haaaa, 16'h5555));
        send_request(query_req(17'h0aaab, 17'h05556, 17'h05557));
        send_request(query_req(17'h15555, 17'h0aaab, 17'h10000));
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            if ($urandom_range(0, 99) < ((inserts_sent < CAPACITY) ? 55 : 15))
                send_request(insert_req(pick_coord(), pick_coord()));
            else
                send_request(random_query());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && answers_pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Response side: random stalls, and two long hold-offs that back up the request side.
    initial begin
        int stall;
        int burst;
        int taken;
        burst = 0;
        taken = 0;
        rsp_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (taken == 300 || taken == 1200) begin
                stall = HOLD_CYCLES;
            end else if (burst > 0) begin
                stall = 0;
                burst--;
            end else begin
                stall = $urandom_range(0, 19);
                if ($urandom_range(0, 24) == 0)
                    burst = $urandom_range(10, 40);
            end
            if (stall > 0) begin
                rsp_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready = 1'b1;
            do @(posedge i_clk); while (rsp_ch.valid !== 1'b1);
            taken++;
            @(negedge i_clk);
        end
    end

    // End the run when no beat moves on either channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
